### sv/wsg_pkg.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator package
// Shared constants, types and state codes for the six-channel generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

	localparam int NumChannels = 6;
	localparam int WaveLength  = 32;
	localparam int ChW         = 3;
	localparam int IdxW        = 5;
	localparam int WaveAddrW   = 8;
	localparam int PhaseW      = 17;
	localparam int PeriodW     = 12;
	localparam int SampleW     = 14;
	localparam int QuotW       = 19;

	localparam logic [QuotW-1:0] PhaseBase = 19'd335625;

	localparam logic [15:0] AddrSelect  = 16'h0800;
	localparam logic [15:0] AddrMaster  = 16'h0801;
	localparam logic [15:0] AddrFreqLo  = 16'h0802;
	localparam logic [15:0] AddrFreqHi  = 16'h0803;
	localparam logic [15:0] AddrControl = 16'h0804;
	localparam logic [15:0] AddrBalance = 16'h0805;
	localparam logic [15:0] AddrWave    = 16'h0806;
	localparam logic [15:0] AddrNoise   = 16'h0807;
	localparam logic [15:0] AddrLfoRate = 16'h0808;
	localparam logic [15:0] AddrLfoCtl  = 16'h0809;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_CHAN,
		ST_DIV,
		ST_MIX,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic [PeriodW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [QuotW-1:0] quotient;
	} div_rsp_t;

endpackage

### sv/wsg_divider.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator divider
// Restoring divider that forms the phase step, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsg_divider
	import wsg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [QuotW-1:0]   quot_q;
	logic [PeriodW-1:0] rem_q;
	logic [PeriodW-1:0] dvs_q;
	logic [4:0]         cnt_q;
	logic               busy_q;
	logic [PeriodW:0]   trial;
	logic [PeriodW:0]   diff;

	assign trial = {rem_q, quot_q[QuotW-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(QuotW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= PhaseBase;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			if (!diff[PeriodW]) begin
				rem_q  <= diff[PeriodW-1:0];
				quot_q <= {quot_q[QuotW-2:0], 1'b1};
			end else begin
				rem_q  <= trial[PeriodW-1:0];
				quot_q <= {quot_q[QuotW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = busy_q && (cnt_q == 5'd1);
	assign rsp.quotient = (!diff[PeriodW]) ? {quot_q[QuotW-2:0], 1'b1}
		: {quot_q[QuotW-2:0], 1'b0};

endmodule

### sv/wavetable_sound_generator.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator
// A write request is taken while idle and busy stays low. A sample request
// holds busy while each channel in range is skipped or, if mixed, has its
// phase step formed in the serial divider; the result strobe rises in the same
// cycle that busy falls and cannot be stalled.
// After reset a clearing pass empties the wave memory.
// ----------------------------------------------------------------------------
module wavetable_sound_generator
	import wsg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [15:0]        address,
	input  logic [7:0]         write_data,
	output logic               strobe,
	output logic [SampleW-1:0] left_sample,
	output logic [SampleW-1:0] right_sample
);

	state_t state_q, state_d;

	logic [ChW-1:0]     sel_q;
	logic [7:0]         master_q, noise_q, lfo_rate_q, lfo_ctl_q;
	logic [PeriodW-1:0] period_q [NumChannels];
	logic [7:0]         ctl_q [NumChannels];
	logic [7:0]         bal_q [NumChannels];
	logic [IdxW-1:0]    widx_q [NumChannels];
	logic [PhaseW-1:0]  phase_q [NumChannels];
	logic [4:0]         wave_mem [NumChannels*WaveLength];
	logic [4:0]         rd_q;
	logic [WaveAddrW-1:0] clr_q;
	logic [ChW-1:0]     ch_q;
	logic [ChW-1:0]     last_q;
	logic [SampleW-1:0] left_q, right_q;
	logic               strobe_q;
	logic               wr_req;
	logic               mixed;
	logic [ChW-1:0]     first_ch;
	logic [ChW-1:0]     last_ch;
	logic [6:0]         lv, rv;
	logic [11:0]        lprod, rprod;
	logic [QuotW-1:0]   step;
	div_req_t           dreq;
	div_rsp_t           drsp;
	logic               chan_valid;
	logic [WaveAddrW-1:0] wr_addr;

	wsg_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign wr_req     = start && !busy && !command;
	assign chan_valid = (sel_q < ChW'(NumChannels));
	assign first_ch   = (lfo_ctl_q[1:0] != 2'b00) ? ChW'(2) : '0;
	assign last_ch    = noise_q[7] ? ChW'(4) : ChW'(NumChannels);
	assign mixed      = (ctl_q[ch_q][7:6] == 2'b10);
	assign wr_addr    = WaveAddrW'(sel_q) * WaveAddrW'(WaveLength) + WaveAddrW'(widx_q[sel_q]);
	assign step       = (period_q[ch_q] == '0) ? '0 : drsp.quotient;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start && command) state_d = ST_CHAN;
			ST_CLEAR: if (clr_q == WaveAddrW'(NumChannels*WaveLength-1)) state_d = ST_IDLE;
			ST_CHAN: begin
				if (ch_q >= last_q) state_d = ST_DONE;
				else if (mixed) state_d = ST_DIV;
			end
			ST_DIV:   if (drsp.done) state_d = ST_MIX;
			ST_MIX:   state_d = ST_CHAN;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy         = (state_q != ST_IDLE);
		dreq.start   = (state_q == ST_CHAN) && (ch_q < last_q) && mixed;
		dreq.divisor = period_q[ch_q];
	end

	always_comb begin
		lv    = 7'(master_q[7:4]) + 7'(bal_q[ch_q][7:4]) + 7'(ctl_q[ch_q][4:0]);
		rv    = 7'(master_q[3:0]) + 7'(bal_q[ch_q][3:0]) + 7'(ctl_q[ch_q][4:0]);
		lprod = 12'(lv) * 12'(rd_q);
		rprod = 12'(rv) * 12'(rd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			ch_q       <= '0;
			last_q     <= '0;
			strobe_q   <= 1'b0;
			sel_q      <= '0;
			master_q   <= '0;
			noise_q    <= '0;
			lfo_rate_q <= '0;
			lfo_ctl_q  <= '0;
			for (int i = 0; i < NumChannels; i++) begin
				period_q[i] <= '0;
				ctl_q[i]    <= '0;
				bal_q[i]    <= '0;
				widx_q[i]   <= '0;
				phase_q[i]  <= '0;
			end
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == ST_DONE);
			if (state_q == ST_CLEAR) clr_q <= clr_q + WaveAddrW'(1);
			if (state_q == ST_IDLE && start && command) begin
				ch_q   <= first_ch;
				last_q <= last_ch;
			end
			if (state_q == ST_CHAN && ch_q < last_q && !mixed) ch_q <= ch_q + ChW'(1);
			if (state_q == ST_DIV && drsp.done) begin
				phase_q[ch_q] <= phase_q[ch_q] + PhaseW'(step);
			end
			if (state_q == ST_MIX) ch_q <= ch_q + ChW'(1);
			if (wr_req) begin
				unique case (address)
					AddrSelect:  sel_q <= write_data[2:0];
					AddrMaster:  master_q <= write_data;
					AddrFreqLo:  if (chan_valid) period_q[sel_q][7:0] <= write_data;
					AddrFreqHi:  if (chan_valid) period_q[sel_q][11:8] <= write_data[3:0];
					AddrControl: if (chan_valid) begin
						ctl_q[sel_q] <= write_data;
						if (write_data[7:6] == 2'b01) widx_q[sel_q] <= '0;
					end
					AddrBalance: if (chan_valid) bal_q[sel_q] <= write_data;
					AddrWave:    if (chan_valid) widx_q[sel_q] <= widx_q[sel_q] + IdxW'(1);
					AddrNoise:   noise_q <= write_data;
					AddrLfoRate: lfo_rate_q <= write_data;
					AddrLfoCtl:  lfo_ctl_q <= write_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			wave_mem[clr_q] <= '0;
		end else if (wr_req && address == AddrWave && chan_valid) begin
			wave_mem[wr_addr] <= write_data[4:0];
		end
		rd_q <= wave_mem[WaveAddrW'(ch_q) * WaveAddrW'(WaveLength)
			+ WaveAddrW'(phase_q[ch_q][PhaseW-1:12])];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start && command) begin
			left_q  <= '0;
			right_q <= '0;
		end else if (state_q == ST_MIX) begin
			left_q  <= left_q + SampleW'(lprod);
			right_q <= right_q + SampleW'(rprod);
		end
	end

	assign strobe       = strobe_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;

	logic unused_ok;
	assign unused_ok = ^lfo_rate_q;

endmodule
